>>> hdl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// shared constants, codes and control types of the set membership table
// ----------------------------------------------------------------------------
package smt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ELEM_W   = 32;
	localparam int OP_W     = 2;
	localparam int SIZE_W   = 7;
	localparam int OUT_W    = 16;

	typedef logic [OP_W-1:0] opcode_t;

	localparam opcode_t OP_ADD    = 2'd0;
	localparam opcode_t OP_REMOVE = 2'd1;
	localparam opcode_t OP_SEARCH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic commit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr;
		logic out_free;
	} stat_t;

endpackage

>>> hdl/smt_ram.sv
// ----------------------------------------------------------------------------
// smt_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module smt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl
// sequencer: accept a request, sweep all slots, then commit the result
// ----------------------------------------------------------------------------
module smt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  smt_pkg::stat_t stat,
	output smt_pkg::ctl_t  ctl
);

	import smt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.last_addr) state_d = ST_LAST;
			end
			ST_LAST: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		ctl.accept = 1'b0;
		ctl.rd_en  = 1'b0;
		ctl.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				ctl.accept = s_tvalid;
			end
			ST_SCAN: begin
				ctl.rd_en = 1'b1;
			end
			ST_LAST: begin
				// final compare lands this cycle
			end
			ST_COMMIT: begin
				ctl.commit = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/smt_dp.sv
// ----------------------------------------------------------------------------
// smt_dp
// datapath: slot memory, valid map, count, compare stage and result register
// ----------------------------------------------------------------------------
module smt_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smt_pkg::ctl_t               ctl,
	output smt_pkg::stat_t              stat,
	input  logic signed [smt_pkg::ELEM_W-1:0] in_element,
	input  smt_pkg::opcode_t            in_opcode,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [smt_pkg::OUT_W-1:0]   out_data
);

	import smt_pkg::*;

	logic [ELEM_W-1:0]   elem_q;
	opcode_t             op_q;
	logic [IDX_W-1:0]    addr_q;
	logic                rd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [ELEM_W-1:0]   rdata;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	logic             match;
	logic             add_ok;
	logic             rem_ok;
	logic             full;
	logic             success;
	logic [CNT_W-1:0] count_d;

	smt_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ctl.commit & add_ok),
		.waddr(free_idx_q),
		.wdata(elem_q),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign match = valid_q[idx_s1] && (rdata == elem_q);

	// free_q alone implies room: a free slot exists only below capacity
	assign add_ok  = (op_q == OP_ADD) && !hit_q && free_q;
	assign full    = (op_q == OP_ADD) && !hit_q && !free_q;
	assign rem_ok  = (op_q == OP_REMOVE) && hit_q;
	assign success = add_ok || rem_ok || ((op_q == OP_SEARCH) && hit_q);

	always_comb begin
		count_d = count_q;
		if (add_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign stat.last_addr = (addr_q == IDX_W'(CAPACITY - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			elem_q <= in_element;
			op_q   <= in_opcode;
		end
		idx_s1 <= addr_q;
		if (rd_s1 && match && !hit_q) begin
			hit_idx_q <= idx_s1;
		end
		if (rd_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (ctl.commit) begin
			out_data_q <= OUT_W'({full, (count_d == '0), SIZE_W'(count_d), success});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_s1       <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= ctl.rd_en;
			if (ctl.accept) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (ctl.rd_en) begin
					addr_q <= addr_q + IDX_W'(1);
				end
				if (rd_s1 && match) begin
					hit_q <= 1'b1;
				end
				if (rd_s1 && !valid_q[idx_s1]) begin
					free_q <= 1'b1;
				end
			end
			if (ctl.commit) begin
				count_q <= count_d;
				if (add_ok) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (rem_ok) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hdl/set_membership_table_core.sv
// ----------------------------------------------------------------------------
// set_membership_table_core
// bounded set of distinct 32-bit elements with add, remove and search
//
//   channel  dir  payload
//   s_*      in   tdata: element, tuser: opcode
//   m_*      out  tdata: success, set_size, is_empty, rejected_full
//
// each request sweeps the slots in turn, one memory read per slot on the
// single read port, then waits for the registered read data, then commits.
// a new request is taken in the cycle after commit, while the previous
// result may still wait in the output register.
// reset clears the valid map and the count at once; no clearing pass.
// a stalled output holds the commit until the output register frees up.
// ----------------------------------------------------------------------------
module set_membership_table_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic signed [smt_pkg::ELEM_W-1:0] s_tdata,  // [31:0] element
	input  logic [smt_pkg::OP_W-1:0]          s_tuser,  // [1:0] opcode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] success, [7:1] set_size, [8] is_empty, [9] rejected_full, [15:10] zero
	output logic [smt_pkg::OUT_W-1:0]         m_tdata
);

	import smt_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	smt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	smt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_element(s_tdata),
		.in_opcode (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> dv/set_membership_table_core_test.sv
// ----------------------------------------------------------------------------
// set_membership_table_core_test
// self-checking bench for the bounded set: add, remove and search requests go
// in on the s_* stream with random gaps, a scoreboard model of the slots and
// the element count predicts every result, and each result taken from the
// m_* stream under random back-pressure is compared field by field
// ----------------------------------------------------------------------------
module set_membership_table_core_test;

	import smt_pkg::*;

	localparam opcode_t OP_NONE   = 2'd3;
	localparam int      POOL_SIZE = 96;
	localparam int      CYCLE_CAP = 1500000;
	localparam int      DRAIN_CYC = 80;

	// first member lands in the top bit, so the lowest field comes last
	typedef struct packed {
		logic              rejected_full;
		logic              is_empty;
		logic [SIZE_W-1:0] set_size;
		logic              success;
	} set_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ELEM_W-1:0] s_tdata = '0;     // [31:0] element
	logic [OP_W-1:0]   s_tuser = '0;     // [1:0] opcode
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;          // [0] success, [7:1] set_size, [8] is_empty,
	                                     // [9] rejected_full, [15:10] zero

	// scoreboard copy of the table
	logic [ELEM_W-1:0] slot_value [CAPACITY];
	logic              slot_used  [CAPACITY];
	int                held_count;

	set_result_t       pending_results [$];
	logic [ELEM_W-1:0] element_pool [POOL_SIZE];
	logic              idle_on = 1'b1;
	int                error_count = 0;
	int                cycle_count = 0;

	set_membership_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	// mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// lookup and free-slot search over the whole table, then the update
	function automatic set_result_t apply_request(opcode_t op, logic [ELEM_W-1:0] elem);
		int          hit;
		int          vacant;
		set_result_t r;
		hit = -1;
		vacant = -1;
		r = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (slot_used[i] && slot_value[i] == elem && hit < 0)
				hit = i;
			if (!slot_used[i] && vacant < 0)
				vacant = i;
		end
		case (op)
			OP_ADD: begin
				if (hit < 0) begin
					if (vacant < 0) begin
						r.rejected_full = 1'b1;
					end else begin
						slot_value[vacant] = elem;
						slot_used[vacant] = 1'b1;
						held_count++;
						r.success = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					held_count--;
					r.success = 1'b1;
				end
			end
			OP_SEARCH: begin
				r.success = (hit >= 0);
			end
			default: begin
			end
		endcase
		r.set_size = held_count[SIZE_W-1:0];
		r.is_empty = (held_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		error_count++;
	endtask

	// called at a rising edge; leaves s_tvalid high after the request is taken
	task automatic send_request(input opcode_t op, input logic [ELEM_W-1:0] elem);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= elem;
		s_tuser  <= op;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		pending_results.push_back(apply_request(op, elem));
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		int stall_left;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 25) begin
			stall_left = pick_gap();
			m_tready <= (stall_left == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// values are stable at the falling edge; the result is taken at the next rise
	always @(negedge clk) begin
		set_result_t want;
		set_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[9:0];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result, data %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.success !== want.success)
					report_mismatch($sformatf("success exp %0d got %0d",
						want.success, got.success));
				if (got.set_size !== want.set_size)
					report_mismatch($sformatf("set_size exp %0d got %0d",
						want.set_size, got.set_size));
				if (got.is_empty !== want.is_empty)
					report_mismatch($sformatf("is_empty exp %0d got %0d",
						want.is_empty, got.is_empty));
				if (got.rejected_full !== want.rejected_full)
					report_mismatch($sformatf("rejected_full exp %0d got %0d",
						want.rejected_full, got.rejected_full));
			end
		end
	end

	task automatic test_directed_corners();
		send_request(OP_SEARCH, 32'h0000_0000);
		send_request(OP_REMOVE, 32'h8000_0000);
		send_request(OP_NONE,   32'h0000_0000);
		send_request(OP_ADD,    32'h8000_0000);
		send_request(OP_ADD,    32'h7fff_ffff);
		send_request(OP_ADD,    32'h0000_0000);
		send_request(OP_ADD,    32'hffff_ffff);
		send_request(OP_ADD,    32'h8000_0000);
		send_request(OP_SEARCH, 32'h7fff_ffff);
		send_request(OP_SEARCH, 32'h7fff_fffe);
		send_request(OP_NONE,   32'hffff_ffff);
		send_request(OP_REMOVE, 32'h0000_0000);
		send_request(OP_REMOVE, 32'h0000_0000);
		send_request(OP_SEARCH, 32'h0000_0000);
		send_request(OP_ADD,    32'h5555_5555);
		send_request(OP_ADD,    32'haaaa_aaaa);
		send_request(OP_REMOVE, 32'h8000_0000);
		send_request(OP_REMOVE, 32'h7fff_ffff);
		send_request(OP_REMOVE, 32'hffff_ffff);
		send_request(OP_REMOVE, 32'h5555_5555);
		send_request(OP_REMOVE, 32'haaaa_aaaa);
	endtask

	// fill every slot, push past the limit, reuse a freed slot, then empty it
	task automatic test_fill_and_overflow();
		logic [ELEM_W-1:0] fill_vals [CAPACITY];
		logic [ELEM_W-1:0] extra;
		for (int i = 0; i < CAPACITY; i++) begin
			fill_vals[i] = $urandom();
			send_request(OP_ADD, fill_vals[i]);
		end
		send_request(OP_ADD, $urandom());
		send_request(OP_ADD, fill_vals[CAPACITY/2]);
		send_request(OP_SEARCH, fill_vals[CAPACITY-1]);
		send_request(OP_REMOVE, fill_vals[10]);
		extra = $urandom();
		send_request(OP_ADD, extra);
		send_request(OP_ADD, fill_vals[10]);
		fill_vals[10] = extra;
		for (int i = CAPACITY - 1; i >= 0; i--)
			send_request(OP_REMOVE, fill_vals[i]);
	endtask

	task automatic test_random_traffic(input int count, input int add_pct, input int remove_pct);
		int                r;
		opcode_t           op;
		logic [ELEM_W-1:0] elem;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				op = OP_NONE;
			else if (r < 2 + add_pct)
				op = OP_ADD;
			else if (r < 2 + add_pct + remove_pct)
				op = OP_REMOVE;
			else
				op = OP_SEARCH;
			// pool values make hits likely, fresh ones are mostly misses
			if ($urandom_range(0, 99) < 85)
				elem = element_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				elem = $urandom();
			send_request(op, elem);
		end
	endtask

	initial begin
		for (int i = 0; i < CAPACITY; i++) begin
			slot_value[i] = '0;
			slot_used[i] = 1'b0;
		end
		held_count = 0;
		element_pool[0] = 32'h8000_0000;
		element_pool[1] = 32'h7fff_ffff;
		element_pool[2] = 32'h0000_0000;
		element_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			element_pool[i] = $urandom();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_fill_and_overflow();
		for (int phase = 0; phase < 8; phase++) begin
			idle_on <= (phase % 3 != 2);
			case (phase % 3)
				0: test_random_traffic(200, 60, 20);
				1: test_random_traffic(200, 20, 60);
				default: test_random_traffic(200, 40, 40);
			endcase
		end
		idle_on <= 1'b1;

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
